// ===== hdl/mqpa_pkg.sv =====
// types and codes for the bank of age-sorted priority queues
// no dependencies; used by multi_queue_priority_by_age
package mqpa_pkg;

    localparam int ID_W   = 16;
    localparam int AGE_W  = 8;
    localparam int QNUM_W = 3;

    localparam logic KIND_ENTER = 1'b0;
    localparam logic KIND_LEAVE = 1'b1;

    localparam logic [1:0] ST_ENTERED = 2'd0;
    localparam logic [1:0] ST_LEFT    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_DROPPED = 2'd3;

    typedef struct packed {
        logic              kind;
        logic [QNUM_W-1:0] queue_number;
        logic [ID_W-1:0]   client_id;
        logic [AGE_W-1:0]  age;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [ID_W-1:0]  leaving_id;
        logic [AGE_W-1:0] leaving_age;
    } out_item_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [AGE_W-1:0] age;
    } entry_t;

endpackage

// ===== hdl/multi_queue_priority_by_age.sv =====
// bank of priority queues sorted by ascending age, one shared entry memory
// depends on mqpa_pkg for beat types, status and kind codes
//
// a drop, an empty leave or an enter into an empty queue is done from S_DECIDE, a leave from S_POP,
// any other enter from S_SCAN or S_PLACE after moving k entries up in S_SCAN (k < QUEUE_DEPTH)
// busy while a beat is in progress; a new beat is taken in the done cycle
// the beat rate is set by the read-compare-write loop on the single entry memory,
// one entry moved per cycle; done cannot be stalled by the receiver
// reset clears the fill counts and control only; entry memory is not cleared
module multi_queue_priority_by_age #(
    parameter int NUM_QUEUES  = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  mqpa_pkg::in_item_t  item,
    output logic                busy,
    output logic                done,
    output mqpa_pkg::out_item_t result
);

    localparam int QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int DW  = $clog2(QUEUE_DEPTH);
    localparam int FW  = $clog2(QUEUE_DEPTH + 1);
    localparam int AW  = QIW + DW;
    localparam int MEM_DEPTH = (1 << QIW) * (1 << DW);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_PLACE  = 3'd3;
    localparam logic [2:0] S_POP    = 3'd4;

    logic [2:0]          state_reg, state_next;
    mqpa_pkg::in_item_t  item_reg, item_next;
    logic [QIW-1:0]      q_idx_reg, q_idx_next;
    logic                q_ok_reg, q_ok_next;
    logic [FW-1:0]       j_reg, j_next;
    logic                done_reg, done_next;
    mqpa_pkg::out_item_t result_reg, result_next;
    logic [FW-1:0]       fill_reg [NUM_QUEUES];

    mqpa_pkg::entry_t    mem [MEM_DEPTH];
    mqpa_pkg::entry_t    rd_data_reg;
    mqpa_pkg::entry_t    wr_data;
    mqpa_pkg::entry_t    new_entry;
    logic                wr_en, rd_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic                fill_we;
    logic [FW-1:0]       fill_wdata;
    logic [FW-1:0]       cur_fill;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    assign new_entry.id  = item_reg.client_id;
    assign new_entry.age = item_reg.age;
    assign cur_fill      = q_ok_reg ? fill_reg[q_idx_reg] : '0;

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        q_idx_next  = q_idx_reg;
        q_ok_next   = q_ok_reg;
        j_next      = j_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = new_entry;
        rd_en       = 1'b0;
        rd_addr     = '0;
        fill_we     = 1'b0;
        fill_wdata  = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    q_idx_next = QIW'(item.queue_number);
                    q_ok_next  = (32'(item.queue_number) < NUM_QUEUES);
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (item_reg.kind == mqpa_pkg::KIND_ENTER)
                begin
                    if (!q_ok_reg || cur_fill == FW'(QUEUE_DEPTH))
                    begin
                        done_next   = 1'b1;
                        result_next = '{mqpa_pkg::ST_DROPPED, '0, '0};
                        state_next  = S_IDLE;
                    end
                    else if (cur_fill == '0)
                    begin
                        wr_en       = 1'b1;
                        wr_addr     = {q_idx_reg, DW'(0)};
                        fill_we     = 1'b1;
                        fill_wdata  = FW'(1);
                        done_next   = 1'b1;
                        result_next = '{mqpa_pkg::ST_ENTERED, '0, '0};
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        j_next     = cur_fill;
                        rd_en      = 1'b1;
                        rd_addr    = {q_idx_reg, DW'(cur_fill - FW'(1))};
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    if (!q_ok_reg || cur_fill == '0)
                    begin
                        done_next   = 1'b1;
                        result_next = '{mqpa_pkg::ST_EMPTY, '0, '0};
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = {q_idx_reg, DW'(cur_fill - FW'(1))};
                        fill_we    = 1'b1;
                        fill_wdata = cur_fill - FW'(1);
                        state_next = S_POP;
                    end
                end
            end
            S_SCAN:
            begin
                wr_en   = 1'b1;
                wr_addr = {q_idx_reg, DW'(j_reg)};
                if (rd_data_reg.age >= item_reg.age)
                begin
                    wr_data = rd_data_reg;
                    j_next  = j_reg - FW'(1);
                    if (j_reg == FW'(1))
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = {q_idx_reg, DW'(j_reg - FW'(2))};
                    end
                end
                else
                begin
                    fill_we     = 1'b1;
                    fill_wdata  = cur_fill + FW'(1);
                    done_next   = 1'b1;
                    result_next = '{mqpa_pkg::ST_ENTERED, '0, '0};
                    state_next  = S_IDLE;
                end
            end
            S_PLACE:
            begin
                wr_en       = 1'b1;
                wr_addr     = {q_idx_reg, DW'(0)};
                fill_we     = 1'b1;
                fill_wdata  = cur_fill + FW'(1);
                done_next   = 1'b1;
                result_next = '{mqpa_pkg::ST_ENTERED, '0, '0};
                state_next  = S_IDLE;
            end
            S_POP:
            begin
                done_next   = 1'b1;
                result_next = '{mqpa_pkg::ST_LEFT, rd_data_reg.id, rd_data_reg.age};
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (fill_we)
            begin
                fill_reg[q_idx_reg] <= fill_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        q_idx_reg  <= q_idx_next;
        q_ok_reg   <= q_ok_next;
        j_reg      <= j_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

`ifndef ASSERT_OFF
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done strobe without a preceding busy cycle");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && q_ok_reg) |-> (fill_reg[q_idx_reg] <= FW'(QUEUE_DEPTH)))
        else $error("queue fill count above depth");

    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != mqpa_pkg::ST_LEFT)
            |-> (result.leaving_id == '0 && result.leaving_age == '0))
        else $error("leaving fields not zero for a non-leave result");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for multi_queue_priority_by_age: a directed table, then random
// enter/leave beats under three sender idling patterns, each checked against a predictor
// depends on mqpa_pkg and the multi_queue_priority_by_age rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_Q          = 8;
    localparam int DEPTH          = 16;
    localparam int DIR_ROWS       = 24;
    localparam int RAND_PER_PHASE = 170;
    localparam int DRAIN_LIMIT    = 2000;
    localparam int TAIL_CYCLES    = 24;

    typedef struct packed {
        mqpa_pkg::in_item_t  it;
        logic [4:0]          reps;
        logic                typed;
        mqpa_pkg::out_item_t want;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    mqpa_pkg::in_item_t  item;
    logic                busy;
    logic                done;
    mqpa_pkg::out_item_t result;

    mqpa_pkg::entry_t    bank [NUM_Q][DEPTH];
    int                  fill_count [NUM_Q];
    mqpa_pkg::out_item_t pending_results [$];
    mqpa_pkg::out_item_t want_r;
    mqpa_pkg::out_item_t got_r;
    int                  err_count;
    int                  items_sent;
    int                  results_checked;
    int                  status_seen [4];
    int                  idle_pct;
    stim_row_t           dir_rows [DIR_ROWS];

    multi_queue_priority_by_age #(
        .NUM_QUEUES  (NUM_Q),
        .QUEUE_DEPTH (DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        err_count++;
    endtask

    function automatic mqpa_pkg::out_item_t apply_queue_op(input mqpa_pkg::in_item_t it);
        mqpa_pkg::out_item_t res;
        int q;
        int j;
        res = '0;
        q = int'(it.queue_number);
        if (q >= NUM_Q)
        begin
            res.status = (it.kind == mqpa_pkg::KIND_LEAVE) ? mqpa_pkg::ST_EMPTY
                                                           : mqpa_pkg::ST_DROPPED;
        end
        else if (it.kind == mqpa_pkg::KIND_ENTER)
        begin
            if (fill_count[q] >= DEPTH)
            begin
                res.status = mqpa_pkg::ST_DROPPED;
            end
            else
            begin
                j = fill_count[q];
                while (j > 0 && bank[q][j-1].age >= it.age)
                begin
                    bank[q][j] = bank[q][j-1];
                    j--;
                end
                bank[q][j].id  = it.client_id;
                bank[q][j].age = it.age;
                fill_count[q]++;
                res.status = mqpa_pkg::ST_ENTERED;
            end
        end
        else if (fill_count[q] == 0)
        begin
            res.status = mqpa_pkg::ST_EMPTY;
        end
        else
        begin
            fill_count[q]--;
            res.status      = mqpa_pkg::ST_LEFT;
            res.leaving_id  = bank[q][fill_count[q]].id;
            res.leaving_age = bank[q][fill_count[q]].age;
        end
        return res;
    endfunction

    task automatic send_beat(input mqpa_pkg::in_item_t it, input bit use_typed,
                             input mqpa_pkg::out_item_t typed_res);
        mqpa_pkg::out_item_t predicted;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = apply_queue_op(it);
        if (use_typed)
            predicted = typed_res;
        pending_results = {pending_results, predicted};
        items_sent++;
    endtask

    task automatic drain_pending();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            got_r = result;
            status_seen[got_r.status]++;
            if (pending_results.size() == 0)
            begin
                flag_mismatch("result strobe with no result pending");
            end
            else
            begin
                want_r = pending_results.pop_front();
                results_checked++;
                if (got_r.status !== want_r.status)
                    flag_mismatch($sformatf("status got %0d want %0d",
                                            got_r.status, want_r.status));
                if (got_r.leaving_id !== want_r.leaving_id)
                    flag_mismatch($sformatf("leaving_id got %h want %h",
                                            got_r.leaving_id, want_r.leaving_id));
                if (got_r.leaving_age !== want_r.leaving_age)
                    flag_mismatch($sformatf("leaving_age got %h want %h",
                                            got_r.leaving_age, want_r.leaving_age));
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("timeout with %0d results pending", pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        mqpa_pkg::in_item_t rnd;
        int                 hot [2];
        int                 enter_pct;
        int                 waited;

        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        err_count = 0;
        items_sent = 0;
        results_checked = 0;
        idle_pct  = 9;
        enter_pct = 50;
        hot[0]    = 0;
        hot[1]    = 1;
        foreach (fill_count[i])
            fill_count[i] = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;

        // kind, queue, id, age | reps, typed | status, id, age
        dir_rows = '{
            {mqpa_pkg::KIND_LEAVE, 3'd0, 16'h0000, 8'h00, 5'd1,  1'b1,
             mqpa_pkg::ST_EMPTY,   16'h0000, 8'h00},
            {mqpa_pkg::KIND_LEAVE, 3'd7, 16'hFFFF, 8'hFF, 5'd1,  1'b1,
             mqpa_pkg::ST_EMPTY,   16'h0000, 8'h00},
            {mqpa_pkg::KIND_ENTER, 3'd0, 16'hFFFF, 8'hFF, 5'd1,  1'b1,
             mqpa_pkg::ST_ENTERED, 16'h0000, 8'h00},
            {mqpa_pkg::KIND_ENTER, 3'd0, 16'h0000, 8'h00, 5'd1,  1'b1,
             mqpa_pkg::ST_ENTERED, 16'h0000, 8'h00},
            {mqpa_pkg::KIND_ENTER, 3'd0, 16'h1234, 8'hFF, 5'd1,  1'b1,
             mqpa_pkg::ST_ENTERED, 16'h0000, 8'h00},
            {mqpa_pkg::KIND_ENTER, 3'd0, 16'h8001, 8'h80, 5'd1,  1'b0,
             mqpa_pkg::ST_ENTERED, 16'h0000, 8'h00},
            {mqpa_pkg::KIND_LEAVE, 3'd0, 16'h0000, 8'h00, 5'd1,  1'b1,
             mqpa_pkg::ST_LEFT,    16'hFFFF, 8'hFF},
            {mqpa_pkg::KIND_LEAVE, 3'd0, 16'hFFFF, 8'hFF, 5'd1,  1'b1,
             mqpa_pkg::ST_LEFT,    16'h1234, 8'hFF},
            {mqpa_pkg::KIND_LEAVE, 3'd0, 16'h0000, 8'h00, 5'd1,  1'b1,
             mqpa_pkg::ST_LEFT,    16'h8001, 8'h80},
            {mqpa_pkg::KIND_LEAVE, 3'd0, 16'h0000, 8'h00, 5'd1,  1'b1,
             mqpa_pkg::ST_LEFT,    16'h0000, 8'h00},
            {mqpa_pkg::KIND_LEAVE, 3'd0, 16'h0000, 8'h00, 5'd1,  1'b1,
             mqpa_pkg::ST_EMPTY,   16'h0000, 8'h00},
            {mqpa_pkg::KIND_ENTER, 3'd3, 16'hA500, 8'h40, 5'd16, 1'b0,
             mqpa_pkg::ST_ENTERED, 16'h0000, 8'h00},
            {mqpa_pkg::KIND_ENTER, 3'd3, 16'hFFFF, 8'h40, 5'd1,  1'b1,
             mqpa_pkg::ST_DROPPED, 16'h0000, 8'h00},
            {mqpa_pkg::KIND_ENTER, 3'd3, 16'h0001, 8'h00, 5'd1,  1'b1,
             mqpa_pkg::ST_DROPPED, 16'h0000, 8'h00},
            {mqpa_pkg::KIND_LEAVE, 3'd3, 16'h0000, 8'h00, 5'd1,  1'b1,
             mqpa_pkg::ST_LEFT,    16'hA500, 8'h40},
            {mqpa_pkg::KIND_ENTER, 3'd3, 16'h5A5A, 8'hFF, 5'd1,  1'b0,
             mqpa_pkg::ST_ENTERED, 16'h0000, 8'h00},
            {mqpa_pkg::KIND_ENTER, 3'd3, 16'h0F0F, 8'h00, 5'd1,  1'b1,
             mqpa_pkg::ST_DROPPED, 16'h0000, 8'h00},
            {mqpa_pkg::KIND_LEAVE, 3'd3, 16'h0000, 8'h00, 5'd1,  1'b1,
             mqpa_pkg::ST_LEFT,    16'h5A5A, 8'hFF},
            {mqpa_pkg::KIND_LEAVE, 3'd7, 16'h0000, 8'h00, 5'd1,  1'b1,
             mqpa_pkg::ST_EMPTY,   16'h0000, 8'h00},
            {mqpa_pkg::KIND_ENTER, 3'd7, 16'hFFFF, 8'h00, 5'd1,  1'b0,
             mqpa_pkg::ST_ENTERED, 16'h0000, 8'h00},
            {mqpa_pkg::KIND_ENTER, 3'd7, 16'h0000, 8'hFF, 5'd1,  1'b0,
             mqpa_pkg::ST_ENTERED, 16'h0000, 8'h00},
            {mqpa_pkg::KIND_LEAVE, 3'd7, 16'hFFFF, 8'hFF, 5'd1,  1'b0,
             mqpa_pkg::ST_LEFT,    16'h0000, 8'h00},
            {mqpa_pkg::KIND_LEAVE, 3'd7, 16'h0000, 8'h00, 5'd1,  1'b0,
             mqpa_pkg::ST_LEFT,    16'h0000, 8'h00},
            {mqpa_pkg::KIND_LEAVE, 3'd7, 16'h0000, 8'h00, 5'd1,  1'b1,
             mqpa_pkg::ST_EMPTY,   16'h0000, 8'h00}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            for (int n = 0; n < int'(dir_rows[r].reps); n++)
            begin
                rnd = dir_rows[r].it;
                rnd.client_id = rnd.client_id + 16'(n);
                send_beat(rnd, dir_rows[r].typed, dir_rows[r].want);
            end
        end
        drain_pending();

        for (int p = 0; p < 3; p++)
        begin
            idle_pct = (p == 0) ? 9 : ((p == 1) ? 59 : 0);
            for (int k = 0; k < RAND_PER_PHASE; k++)
            begin
                // two hot queues per stretch of 40 beats so queues fill and empty
                if (k % 40 == 0)
                begin
                    hot[0] = $urandom_range(NUM_Q - 1);
                    hot[1] = $urandom_range(NUM_Q - 1);
                    case ($urandom_range(3))
                        0: enter_pct = 25;
                        1: enter_pct = 50;
                        2: enter_pct = 70;
                        default: enter_pct = 90;
                    endcase
                end
                rnd.kind = ($urandom_range(99) < enter_pct) ? mqpa_pkg::KIND_ENTER
                                                            : mqpa_pkg::KIND_LEAVE;
                rnd.queue_number = ($urandom_range(99) < 75)
                                   ? mqpa_pkg::QNUM_W'(hot[$urandom_range(1)])
                                   : mqpa_pkg::QNUM_W'($urandom_range(NUM_Q - 1));
                rnd.client_id = mqpa_pkg::ID_W'($urandom);
                case ($urandom_range(9)) inside
                    [0:4]: rnd.age = mqpa_pkg::AGE_W'($urandom_range(3));
                    5: rnd.age = '0;
                    6: rnd.age = '1;
                    default: rnd.age = mqpa_pkg::AGE_W'($urandom);
                endcase
                send_beat(rnd, 1'b0, '0);
            end
            drain_pending();
        end

        start <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        while (pending_results.size() != 0)
        begin
            void'(pending_results.pop_front());
            flag_mismatch("expected result never arrived");
        end

        $display("sent %0d beats (directed table, then random under three idling patterns)",
                 items_sent);
        $display("checked %0d results: %0d entered, %0d left, %0d empty, %0d dropped, %0d errors",
                 results_checked, status_seen[mqpa_pkg::ST_ENTERED],
                 status_seen[mqpa_pkg::ST_LEFT], status_seen[mqpa_pkg::ST_EMPTY],
                 status_seen[mqpa_pkg::ST_DROPPED], err_count);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/mqpa_pkg.sv
hdl/multi_queue_priority_by_age.sv
tb/sv/tb_top.sv
